[sv/bvsm_pkg.sv]
// Shared types and constants for the battery voltage stability monitor.
package bvsm_pkg;

    // ADC full-scale code
    localparam logic [11:0] ADC_FULL = 12'hFFF;

    // v = (s*scale*vref + 10*5*FULL) / (10*FULL*div*mult), folded from three divides
    localparam int unsigned DEN_K_INT   = 10 * 4095;
    localparam int unsigned ROUND_K_INT = 10 * 5 * 4095;
    localparam logic [15:0] DEN_K       = 16'(DEN_K_INT);
    localparam logic [36:0] ROUND_K     = 37'(ROUND_K_INT);

    // divider geometry: quotient bits, numerator and denominator widths
    localparam int QUOT_W     = 16;
    localparam int NUM_W      = 37;
    localparam int DEN_W      = 32;
    localparam int DIV_STEPS  = QUOT_W;

    // multiplier operand widths
    localparam int MUL_A_W = 28;
    localparam int MUL_B_W = 16;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // configuration register indexes
    localparam logic [2:0] CFG_SCALE  = 3'd0;
    localparam logic [2:0] CFG_DIV    = 3'd1;
    localparam logic [2:0] CFG_MULT   = 3'd2;
    localparam logic [2:0] CFG_VREF   = 3'd3;
    localparam logic [2:0] CFG_GAIN   = 3'd4;
    localparam logic [2:0] CFG_DELTA  = 3'd5;
    localparam logic [2:0] CFG_TICK   = 3'd6;
    localparam logic [2:0] CFG_THRESH = 3'd7;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

[sv/battery_voltage_stability_monitor_core.sv]
// Battery voltage stability monitor: filter, scaling, stability tracker and sequencer.
// Input channel: i_in_valid / o_in_stall with i_adc_sample and i_now_ms. A transaction
// is taken when valid is high and stall is low; stall stays high while an item is in work.
// Output channel: o_out_valid / i_out_stall with filtered voltage, raw voltage and the
// stability flag, held in an output register until the receiver takes it.
// One shared 28x16 multiplier and one bit-serial divider do the multiplies and divides
// under a small sequencer. The divider gives one quotient bit per cycle and runs twice
// per item, and the block takes no new item until the current one has loaded its result
// into the output register. The next item can be taken while a result waits; it then
// holds its finished result until the output register frees, so a stalled receiver
// holds off the input side.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data); the user writes
// it only while idle; the block does not check this. Reset restores the default register
// values, clears the filter, reference, tick time and history and leaves the block idle.
module battery_voltage_stability_monitor_core #(
    parameter int HISTORY_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [11:0] i_adc_sample,
    input  logic [31:0] i_now_ms,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_filtered_voltage,
    output logic [15:0] o_raw_voltage,
    output logic        o_is_stable,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import bvsm_pkg::*;

    localparam int WIN_W = HISTORY_BITS + 1;
    localparam int CNT_W = $clog2(WIN_W + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FMUL  = 4'd1;
    localparam logic [3:0] S_FUPD  = 4'd2;
    localparam logic [3:0] S_DMUL  = 4'd3;
    localparam logic [3:0] S_FSC   = 4'd4;
    localparam logic [3:0] S_FVR   = 4'd5;
    localparam logic [3:0] S_FDIV  = 4'd6;
    localparam logic [3:0] S_FWAIT = 4'd7;
    localparam logic [3:0] S_TRK   = 4'd8;
    localparam logic [3:0] S_RVR   = 4'd9;
    localparam logic [3:0] S_RDIV  = 4'd10;
    localparam logic [3:0] S_RWAIT = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    // configuration
    logic [7:0]  r_scale, r_div, r_mult;
    logic [15:0] r_vref, r_gain, r_delta, r_tick;
    logic [5:0]  r_thresh;

    // control and state
    logic [3:0]       r_state, n_state;
    logic [27:0]      r_acc, n_acc;
    logic [15:0]      r_ref;
    logic [31:0]      r_last;
    logic [WIN_W-1:0] r_hist, n_hist;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_vld;

    // per-item payload
    logic [11:0]  r_samp;
    logic [31:0]  r_now;
    logic [31:0]  r_den;
    logic [15:0]  r_filt_v;
    logic [15:0]  r_raw_v;
    logic         r_stable;
    logic [15:0]  r_out_filt, r_out_raw;
    logic         r_out_stab;

    // datapath
    logic [MUL_A_W-1:0] w_mul_a;
    logic [MUL_B_W-1:0] w_mul_b;
    logic [MUL_P_W-1:0] w_prod;
    logic               w_div_start;
    logic [NUM_W-1:0]   w_div_num;
    t_div_stat          w_dstat;
    logic [QUOT_W-1:0]  w_quot;

    logic [27:0]  w_target;
    logic         w_up;
    logic [27:0]  w_d;
    logic [27:0]  w_dn_step;
    logic [7:0]   w_div_eff, w_mult_eff;
    logic [15:0]  w_absdiff;
    logic         w_clr;
    logic [31:0]  w_elap;
    logic         w_tick;
    logic [WIN_W-1:0] w_h1;
    logic [CNT_W-1:0] w_cnt1;
    logic         w_in_acc;
    logic         w_out_acc;
    logic         w_load_out;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_acc  = r_out_vld && !i_out_stall;
    assign w_load_out = (r_state == S_DONE) && (!r_out_vld || !i_out_stall);

    // filter error magnitude and direction
    assign w_target  = {r_samp, 16'b0};
    assign w_up      = w_target >= r_acc;
    assign w_d       = w_up ? (w_target - r_acc) : (r_acc - w_target);
    // downward steps round the scaled error up
    assign w_dn_step = 28'(({1'b0, w_prod} + (MUL_P_W+1)'(16'hFFFF)) >> 16);

    assign w_div_eff  = (r_div == 8'd0) ? 8'd1 : r_div;
    assign w_mult_eff = (r_mult == 8'd0) ? 8'd1 : r_mult;

    // stability tracker
    assign w_absdiff = (r_ref > r_filt_v) ? (r_ref - r_filt_v) : (r_filt_v - r_ref);
    assign w_clr     = w_absdiff > r_delta;
    assign w_elap    = r_now - r_last;
    assign w_tick    = !w_elap[31] && (w_elap >= {16'b0, r_tick});
    assign w_h1      = w_clr ? (r_hist & ~WIN_W'(1)) : r_hist;
    assign w_cnt1    = r_cnt - CNT_W'(w_clr & r_hist[0]);

    always_comb begin
        n_hist = w_h1;
        n_cnt  = w_cnt1;
        if (w_tick) begin
            n_hist = (w_h1 << 1) | WIN_W'(1);
            n_cnt  = w_cnt1 - CNT_W'(w_h1[WIN_W-1]) + CNT_W'(1);
        end
    end

    always_comb begin
        n_acc = r_acc;
        if (w_up) begin
            n_acc = r_acc + w_prod[43:16];
        end else begin
            n_acc = r_acc - w_dn_step;
        end
    end

    // multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            S_FMUL: begin
                w_mul_a = w_d;
                w_mul_b = r_gain;
            end
            S_FUPD: begin
                w_mul_a = MUL_A_W'(w_div_eff);
                w_mul_b = MUL_B_W'(w_mult_eff);
            end
            S_DMUL: begin
                w_mul_a = MUL_A_W'(w_prod[15:0]);
                w_mul_b = DEN_K;
            end
            S_FSC: begin
                w_mul_a = MUL_A_W'(r_acc[27:16]);
                w_mul_b = MUL_B_W'(r_scale);
            end
            S_TRK: begin
                w_mul_a = MUL_A_W'(r_samp);
                w_mul_b = MUL_B_W'(r_scale);
            end
            S_FVR, S_RVR: begin
                w_mul_a = w_prod[27:0];
                w_mul_b = r_vref;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_div_start = (r_state == S_FDIV) || (r_state == S_RDIV);
    assign w_div_num   = w_prod[NUM_W-1:0] + ROUND_K;

    bvsm_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    bvsm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (r_den),
        .o_stat  (w_dstat),
        .o_quot  (w_quot)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_FMUL;
            S_FMUL:  n_state = S_FUPD;
            S_FUPD:  n_state = S_DMUL;
            S_DMUL:  n_state = S_FSC;
            S_FSC:   n_state = S_FVR;
            S_FVR:   n_state = S_FDIV;
            S_FDIV:  n_state = S_FWAIT;
            S_FWAIT: if (w_dstat.done) n_state = S_TRK;
            S_TRK:   n_state = S_RVR;
            S_RVR:   n_state = S_RDIV;
            S_RDIV:  n_state = S_RWAIT;
            S_RWAIT: if (w_dstat.done) n_state = S_DONE;
            S_DONE:  if (w_load_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_acc     <= '0;
            r_ref     <= '0;
            r_last    <= '0;
            r_hist    <= '0;
            r_cnt     <= '0;
            r_scale   <= 8'd110;
            r_div     <= 8'd10;
            r_mult    <= 8'd1;
            r_vref    <= 16'd3300;
            r_gain    <= 16'd6554;
            r_delta   <= 16'd10;
            r_tick    <= 16'd500;
            r_thresh  <= 6'd10;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SCALE:  r_scale  <= i_cfg_data[7:0];
                    CFG_DIV:    r_div    <= i_cfg_data[7:0];
                    CFG_MULT:   r_mult   <= i_cfg_data[7:0];
                    CFG_VREF:   r_vref   <= i_cfg_data;
                    CFG_GAIN:   r_gain   <= i_cfg_data;
                    CFG_DELTA:  r_delta  <= i_cfg_data;
                    CFG_TICK:   r_tick   <= i_cfg_data;
                    CFG_THRESH: r_thresh <= i_cfg_data[5:0];
                    default:    r_thresh <= r_thresh;
                endcase
            end

            if (r_state == S_FUPD) begin
                r_acc <= n_acc;
            end

            if (r_state == S_TRK) begin
                if (w_clr) begin
                    r_ref <= r_filt_v;
                end
                if (w_tick) begin
                    r_last <= r_now;
                end
                r_hist <= n_hist;
                r_cnt  <= n_cnt;
            end

            if (w_load_out) begin
                r_out_vld <= 1'b1;
            end else if (w_out_acc) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_samp <= i_adc_sample;
            r_now  <= i_now_ms;
        end
        if (r_state == S_FSC) begin
            r_den <= w_prod[DEN_W-1:0];
        end
        if (r_state == S_FWAIT && w_dstat.done) begin
            r_filt_v <= w_quot;
        end
        if (r_state == S_TRK) begin
            r_stable <= 6'(n_cnt) >= r_thresh;
        end
        if (r_state == S_RWAIT && w_dstat.done) begin
            r_raw_v <= w_quot;
        end
        if (w_load_out) begin
            r_out_filt <= r_filt_v;
            r_out_raw  <= r_raw_v;
            r_out_stab <= r_stable;
        end
    end

    assign o_out_valid        = r_out_vld;
    assign o_filtered_voltage = r_out_filt;
    assign o_raw_voltage      = r_out_raw;
    assign o_is_stable        = r_out_stab;

`ifndef SYNTHESIS
    a_cnt_matches_hist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == CNT_W'($countones(r_hist)))
        else $error("window count out of step with history");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dstat.done |-> (r_state == S_FWAIT || r_state == S_RWAIT))
        else $error("divider finished outside a wait state");

    a_start_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_dstat.busy && !w_dstat.done)
        else $error("divider started while in use");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |=> o_out_valid && r_state == S_IDLE)
        else $error("result load did not present a transaction");
`endif

endmodule

[sv/bvsm_mul.sv]
// Shared 28x16 unsigned multiplier with registered product.
module bvsm_mul (
    input  logic                         i_clk,
    input  logic [bvsm_pkg::MUL_A_W-1:0] i_a,
    input  logic [bvsm_pkg::MUL_B_W-1:0] i_b,
    output logic [bvsm_pkg::MUL_P_W-1:0] o_prod
);
    import bvsm_pkg::*;

    logic [MUL_P_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

[sv/bvsm_div.sv]
// Restoring divider, one quotient bit per cycle, saturating at 16 bits.
module bvsm_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [bvsm_pkg::NUM_W-1:0] i_num,
    input  logic [bvsm_pkg::DEN_W-1:0] i_den,
    output bvsm_pkg::t_div_stat        o_stat,
    output logic [bvsm_pkg::QUOT_W-1:0] o_quot
);
    import bvsm_pkg::*;

    localparam int DSH_W = DEN_W + QUOT_W - 1;
    localparam int CMP_W = DEN_W + QUOT_W;

    logic                 r_busy;
    logic                 r_done;
    logic [3:0]           r_cnt;
    logic [NUM_W-1:0]     r_rem;
    logic [DSH_W-1:0]     r_dsh;
    logic [QUOT_W-1:0]    r_q;
    logic                 w_ge;
    logic                 w_sat;

    assign w_ge  = DSH_W'(r_rem) >= r_dsh;
    // quotient would not fit in 16 bits
    assign w_sat = CMP_W'(i_num) >= {i_den, {QUOT_W{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // done pulses for a saturated start or the last quotient bit
            r_done <= i_start ? w_sat : (r_busy && (r_cnt == 4'(DIV_STEPS - 1)));
            if (i_start) begin
                if (w_sat) begin
                    r_q    <= '1;
                end else begin
                    r_busy <= 1'b1;
                    r_rem  <= i_num;
                    r_dsh  <= {i_den, {(QUOT_W-1){1'b0}}};
                    r_cnt  <= '0;
                    r_q    <= '0;
                end
            end else if (r_busy) begin
                if (w_ge) begin
                    r_rem <= r_rem - r_dsh[NUM_W-1:0];
                end
                r_q   <= {r_q[QUOT_W-2:0], w_ge};
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_q;

endmodule
